// ----- src/vlbp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the variable-length bit packer: payload structs, job format
// and sizing constants. Depends on nothing; every other file imports it.
package vlbp_pkg;

  // Longest chunk, in bits; longer lengths saturate to this
  localparam int MAX_CHUNK = 32;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = BYTE_W - 1;
  localparam int PCNT_W    = $clog2(BYTE_W);

  // Chunk length after saturation
  localparam int LEN_W     = $clog2(MAX_CHUNK + 1);
  // Pending bits plus one chunk
  localparam int ACC_W     = MAX_CHUNK + PEND_W;
  localparam int TOT_W     = $clog2(ACC_W + 1);
  // Bytes one chunk can complete
  localparam int MAX_BYTES = ACC_W / BYTE_W;
  localparam int WORD_W    = MAX_BYTES * BYTE_W;
  localparam int NB_W      = $clog2(MAX_BYTES + 1);
  localparam int BIDX_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  // Job queue between front and back end
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Item function codes
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] chunk_bits;
    logic [5:0]  chunk_len;
  } vlbp_in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } vlbp_out_t;

  // Completed bytes of one item, right aligned, oldest byte highest
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [NB_W-1:0]   nbytes;
  } vlbp_job_t;

  typedef struct packed {
    logic      push;
    vlbp_job_t job;
  } vlbp_push_t;

  typedef struct packed {
    logic full;
    logic valid;
  } vlbp_qstat_t;

endpackage

// ----- src/vlbp_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts items, holds the pending bits and turns each item into
// a job of completed bytes. Depends on vlbp_pkg.
module vlbp_front import vlbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vlbp_in_t    in_data,
  input  vlbp_qstat_t qstat,
  output vlbp_push_t  qpush
);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [PCNT_W-1:0] cnt_r, cnt_nxt;

  logic              accept;
  logic [LEN_W-1:0]  len_sat;
  logic [ACC_W-1:0]  mask;
  logic [ACC_W-1:0]  acc;
  logic [TOT_W-1:0]  total;
  logic [PCNT_W-1:0] new_cnt;
  logic [NB_W-1:0]   nbytes;
  logic [ACC_W-1:0]  emitted;
  logic [BYTE_W-1:0] flush_byte;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    len_sat = (in_data.chunk_len > 6'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK)
                                                  : LEN_W'(in_data.chunk_len);
    mask    = ACC_W'({MAX_CHUNK{1'b1}} >> (LEN_W'(MAX_CHUNK) - len_sat));
    acc     = (ACC_W'(pend_r) << len_sat) | (ACC_W'(in_data.chunk_bits) & mask);
    total   = TOT_W'(cnt_r) + TOT_W'(len_sat);
    new_cnt = total[PCNT_W-1:0];
    nbytes  = NB_W'(total >> PCNT_W);
    emitted = acc >> new_cnt;
    // Pad the pending bits with zeros on the right
    flush_byte = {1'b0, pend_r} << (4'(BYTE_W) - {1'b0, cnt_r});
  end

  always_comb begin
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    qpush.push = 1'b0;
    qpush.job  = '0;
    if (accept) begin
      if (in_data.func == FUNC_FLUSH) begin
        qpush.push       = (cnt_r != '0);
        qpush.job.word   = WORD_W'(flush_byte);
        qpush.job.nbytes = NB_W'(1);
        pend_nxt         = '0;
        cnt_nxt          = '0;
      end else begin
        qpush.push       = (nbytes != '0);
        qpush.job.word   = emitted[WORD_W-1:0];
        qpush.job.nbytes = nbytes;
        pend_nxt         = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << new_cnt);
        cnt_nxt          = new_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- src/vlbp_queue.sv -----
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the byte serializer.
// Depends on vlbp_pkg.
module vlbp_queue import vlbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  vlbp_push_t  qpush,
  input  logic        pop,
  output vlbp_job_t   head,
  output vlbp_qstat_t qstat
);

  vlbp_job_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.valid = (count_r != '0);
  assign qstat.full  = (count_r == QCNT_W'(QDEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (qpush.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(qpush.push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (qpush.push) begin
      mem_r[wr_ptr_r] <= qpush.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- src/vlbp_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the head job, oldest byte first, into the output
// register, one byte per cycle while not stalled. Depends on vlbp_pkg.
module vlbp_back import vlbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  vlbp_job_t   head,
  input  vlbp_qstat_t qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output vlbp_out_t   out_data
);

  logic              out_valid_r, out_valid_nxt;
  vlbp_out_t         out_data_r, out_data_nxt;
  logic [BIDX_W-1:0] idx_r, idx_nxt;

  logic              load;
  logic [NB_W-1:0]   rem;
  logic [BIDX_W-1:0] sel;
  logic              last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    rem  = head.nbytes - NB_W'(1) - NB_W'(idx_r);
    sel  = rem[BIDX_W-1:0];
    last = (rem == '0);
    load = qstat.valid && (!out_valid_r || !out_stall);
    pop  = load && last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.packed_byte = BYTE_W'(head.word >> {sel, 3'b000});
      out_data_nxt.last_byte   = last;
      idx_nxt                  = last ? '0 : idx_r + 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ----- src/variable_length_bit_packer.sv -----
`timescale 1ns / 1ps
// Top level of the MSB-first variable-length bit packer.
// Depends on vlbp_pkg, vlbp_front, vlbp_queue and vlbp_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_stall  | vlbp_in_t: func, chunk_bits, len
//   out_    | output    | out_valid/out_stall| vlbp_out_t: packed_byte, last_byte
//
// An item completes n bytes (0 to 4); the byte serializer moves one byte per
// cycle into the output register while out_stall does not hold it.
// Items enter one per cycle while the two-entry job queue has room.
// Reset (rst_n low, synchronous) clears the pending bits, the queue and the
// output valid. out_stall holds the output register; the queue absorbs jobs
// until full, then in_stall rises.
module variable_length_bit_packer import vlbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  vlbp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output vlbp_out_t out_data
);

  vlbp_push_t  qpush;
  vlbp_qstat_t qstat;
  vlbp_job_t   head;
  logic        pop;

  // Accept items, track pending bits, build jobs of completed bytes
  vlbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .qstat    (qstat),
    .qpush    (qpush)
  );

  // Hold jobs while the output side stalls
  vlbp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qpush (qpush),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Serialize each job, marking its final byte
  vlbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/vlbp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the bit packer, bound to the top level.
// Depends on vlbp_pkg.
module vlbp_checker import vlbp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input vlbp_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input vlbp_out_t out_data
);

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // Reset drains the output and empties the queue
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("in_stall high right after reset");

endmodule

bind variable_length_bit_packer vlbp_checker u_vlbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
